[rtl/lge_pkg.sv]
// Shared constants, command codes and types for the Life generation engine.
// No dependencies; imported by lge_cell_unit and life_generation_engine.
`timescale 1ns / 1ps

package lge_pkg;

  // Grid storage bounds
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);

  // Field and register widths
  localparam int CFG_W    = 7;
  localparam int POP_W    = 13;
  localparam int MIN_DIM  = 2;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Commands
  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Register select (address bit 2)
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Result status
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_OOB = 1'b1;

  // 3x3 neighborhood around one cell; mid[1] is the cell itself
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] mid;
    logic [2:0] dn;
  } lge_win_t;

  // Clamp a size register into the range MIN_DIM..maxv
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] res;
    if (v < CFG_W'(MIN_DIM)) begin
      res = CFG_W'(MIN_DIM);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[rtl/life_generation_engine.sv]
// Life generation engine top level: command sequencer, row memory, APB registers.
// Depends on lge_pkg and lge_cell_unit.
`timescale 1ns / 1ps

// Conway Life (B3/S23) engine on a grid of up to 64 x 64 cells, sized at run time by
// the rows/cols registers (clamped to 2..64). Every request gives exactly one result.
// Set and read do one row read of the grid memory, plus a write for set; clear and
// out-of-bounds set/read are answered from the idle state. In a step the grid is held
// one row per memory word, a three-row window walks down the grid, and a single rule
// unit evaluates one cell per clock; each row has one fetch state and one write-back.
// A new request is taken only when the sequencer is idle and the previous result has
// been taken. Reset and clear mark all rows empty through per-row valid bits, so no
// clearing pass is needed. Cells outside the active area keep their value over steps.

module life_generation_engine import lge_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_col,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic              out_cell_value,
  output logic              out_extinct,
  output logic [POP_W-1:0]  out_population,
  // APB register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SET_WR = 3'd1;
  localparam logic [2:0] S_GET    = 3'd2;
  localparam logic [2:0] S_PRIME  = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;
  localparam logic [2:0] S_CELL   = 3'd5;
  localparam logic [2:0] S_WB     = 3'd6;

  logic [2:0]          state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0]    rows_r, cols_r;

  // latched request and grid size
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic [CFG_W-1:0]    nr_r, nc_r;

  // step walk
  logic [ROW_W-1:0]    r_r;
  logic [COL_W-1:0]    c_r;
  logic [MAX_COLS-1:0] prev_r, cur_r, nxt_r, new_row_r;
  logic [POP_W-1:0]    pop_r;

  // result register
  logic                out_vld_r;
  logic                out_status_r, out_value_r, out_extinct_r;
  logic [POP_W-1:0]    out_pop_r;

  // grid memory, one row per word
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [MAX_COLS-1:0] rd_data_r;
  logic                rd_vld_r;
  logic [MAX_COLS-1:0] rd_row;
  logic [ROW_W-1:0]    mem_raddr, mem_waddr;
  logic                mem_we;
  logic [MAX_COLS-1:0] mem_wdata;

  logic                in_acc, out_acc, clr_all;
  logic                in_grid;
  logic [CFG_W-1:0]    nr_eff, nc_eff;
  logic                last_col, last_row, has_next_row;
  logic                has_l, has_r;
  logic [COL_W-1:0]    cl, cr;
  lge_win_t            win;
  logic                next_alive;
  logic [MAX_COLS-1:0] merged_row;

  // ---------------- APB registers ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(MAX_ROWS);
      cols_r <= CFG_W'(MAX_COLS);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_COLS) cols_r <= pwdata[CFG_W-1:0];
      else                      rows_r <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? APB_DW'(cols_r) : APB_DW'(rows_r);

  // ---------------- handshake ----------------
  assign in_ready  = (state_r == S_IDLE) && !out_vld_r;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_vld_r && out_ready;
  assign out_valid = out_vld_r;

  assign nr_eff  = eff_dim(rows_r, CFG_W'(MAX_ROWS));
  assign nc_eff  = eff_dim(cols_r, CFG_W'(MAX_COLS));
  assign in_grid = (CFG_W'(in_row) < nr_eff) && (CFG_W'(in_col) < nc_eff);
  assign clr_all = in_acc && (in_cmd == CMD_CLEAR);

  // ---------------- grid memory ----------------
  always_comb begin
    unique case (state_r)
      S_IDLE:  mem_raddr = (in_cmd == CMD_STEP) ? '0 : in_row;
      S_PRIME: mem_raddr = ROW_W'(1);
      S_WB:    mem_raddr = r_r + ROW_W'(2);
      default: mem_raddr = row_r;
    endcase
  end

  assign mem_we    = (state_r == S_SET_WR) || (state_r == S_WB);
  assign mem_waddr = (state_r == S_SET_WR) ? row_r : r_r;
  assign mem_wdata = (state_r == S_SET_WR) ? (rd_row | (MAX_COLS'(1) << col_r)) : merged_row;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
    rd_vld_r  <= row_vld_r[mem_raddr];
  end

  // per-row valid bits stand in for clearing the store
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      row_vld_r <= '0;
    end else if (mem_we) begin
      row_vld_r[mem_waddr] <= 1'b1;
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

  // ---------------- neighborhood and rule unit ----------------
  assign cl       = c_r - COL_W'(1);
  assign cr       = c_r + COL_W'(1);
  assign has_l    = (c_r != '0);
  assign has_r    = (CFG_W'(c_r) + CFG_W'(1)) < nc_r;
  assign last_col = (CFG_W'(c_r) + CFG_W'(1)) == nc_r;
  assign last_row = (CFG_W'(r_r) + CFG_W'(1)) == nr_r;
  assign has_next_row = (CFG_W'(r_r) + CFG_W'(1)) < nr_r;

  always_comb begin
    win.up  = {has_r & prev_r[cr], prev_r[c_r], has_l & prev_r[cl]};
    win.mid = {has_r & cur_r[cr],  cur_r[c_r],  has_l & cur_r[cl]};
    win.dn  = {has_r & nxt_r[cr],  nxt_r[c_r],  has_l & nxt_r[cl]};
  end

  lge_cell_unit u_rule (
    .win        (win),
    .next_alive (next_alive)
  );

  // columns outside the active area keep their old value
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      merged_row[i] = (i < int'(nc_r)) ? new_row_r[i] : cur_r[i];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_SET:   state_nxt = in_grid ? S_SET_WR : S_IDLE;
            CMD_READ:  state_nxt = in_grid ? S_GET : S_IDLE;
            CMD_STEP:  state_nxt = S_PRIME;
            CMD_CLEAR: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SET_WR: state_nxt = S_IDLE;
      S_GET:    state_nxt = S_IDLE;
      S_PRIME:  state_nxt = S_FETCH;
      S_FETCH:  state_nxt = S_CELL;
      S_CELL:   state_nxt = last_col ? S_WB : S_CELL;
      S_WB:     state_nxt = last_row ? S_IDLE : S_FETCH;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // request latch and step datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          row_r <= in_row;
          col_r <= in_col;
          nr_r  <= nr_eff;
          nc_r  <= nc_eff;
        end
      end
      S_PRIME: begin
        cur_r  <= rd_row;
        prev_r <= '0;
        r_r    <= '0;
        pop_r  <= '0;
      end
      S_FETCH: begin
        nxt_r <= has_next_row ? rd_row : '0;
        c_r   <= '0;
      end
      S_CELL: begin
        new_row_r[c_r] <= next_alive;
        pop_r          <= pop_r + POP_W'(next_alive);
        c_r            <= c_r + COL_W'(1);
      end
      S_WB: begin
        prev_r <= cur_r;
        cur_r  <= nxt_r;
        r_r    <= r_r + ROW_W'(1);
      end
      default: begin
      end
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc && (in_cmd == CMD_CLEAR ||
                            ((in_cmd == CMD_SET || in_cmd == CMD_READ) && !in_grid))) begin
      out_vld_r <= 1'b1;
    end else if (state_r == S_SET_WR || state_r == S_GET || (state_r == S_WB && last_row)) begin
      out_vld_r <= 1'b1;
    end else if (out_acc) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r  <= (in_cmd == CMD_CLEAR || in_cmd == CMD_STEP || in_grid) ? STAT_OK
                                                                               : STAT_OOB;
      out_value_r   <= 1'b0;
      out_extinct_r <= 1'b0;
      out_pop_r     <= '0;
    end else if (state_r == S_GET) begin
      out_value_r <= rd_row[col_r];
    end else if (state_r == S_WB && last_row) begin
      out_pop_r     <= pop_r;
      out_extinct_r <= (pop_r == '0);
    end
  end

  assign out_status     = out_status_r;
  assign out_cell_value = out_value_r;
  assign out_extinct    = out_extinct_r;
  assign out_population = out_pop_r;

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_extinct_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_extinct) |-> (out_population == '0))
    else $error("extinct flagged with nonzero population");

  a_col_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CELL) |-> (CFG_W'(c_r) < nc_r))
    else $error("step column walked outside active area");

  a_oob_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (!out_cell_value && !out_extinct))
    else $error("error result carries data");

endmodule

[rtl/lge_cell_unit.sv]
// B3/S23 rule unit: counts the eight neighbors of one cell and gives its next state.
// Depends on lge_pkg (lge_win_t).
`timescale 1ns / 1ps

module lge_cell_unit import lge_pkg::*; (
  input  lge_win_t win,
  output logic     next_alive
);

  logic [3:0] nbr_cnt;

  // neighbor count, center cell excluded
  always_comb begin
    nbr_cnt = 4'(win.up[0]) + 4'(win.up[1]) + 4'(win.up[2])
            + 4'(win.mid[0]) + 4'(win.mid[2])
            + 4'(win.dn[0]) + 4'(win.dn[1]) + 4'(win.dn[2]);
  end

  // born with exactly 3, survives with 2 or 3
  assign next_alive = (nbr_cnt == 4'd3) || (win.mid[1] && (nbr_cnt == 4'd2));

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for life_generation_engine: a cell-grid predictor checks every result.
// Depends on lge_pkg and the life_generation_engine RTL; grid size changes go through APB.

module tb;
  import lge_pkg::*;

  // Longest quiet stretch is one 64 x 64 step plus gaps and stalls
  localparam int STALL_LIMIT  = 20000;
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_REQS  = 100;
  localparam int DRAIN_CYCLES = 16;
  localparam int KEEP_N       = 2;
  localparam int BIRTH_N      = 3;
  localparam int POP_SAT      = (1 << POP_W) - 1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } life_req_t;

  typedef struct packed {
    logic             status;
    logic             cell_value;
    logic             extinct;
    logic [POP_W-1:0] population;
  } life_resp_t;

  typedef struct {
    life_req_t  rq;
    life_resp_t rs;
  } due_entry_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_cmd = CMD_READ;
  logic [ROW_W-1:0]  in_row = '0;
  logic [COL_W-1:0]  in_col = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_status;
  logic              out_cell_value;
  logic              out_extinct;
  logic [POP_W-1:0]  out_population;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  life_generation_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_row        (in_row),
    .in_col        (in_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_cell_value(out_cell_value),
    .out_extinct   (out_extinct),
    .out_population(out_population),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted grid and size registers
  bit               grid_now [MAX_ROWS][MAX_COLS];
  logic [CFG_W-1:0] rows_cfg = CFG_W'(MAX_ROWS);
  logic [CFG_W-1:0] cols_cfg = CFG_W'(MAX_COLS);

  life_req_t  cmd_backlog [$];
  due_entry_t due_responses [$];
  int         fail_count = 0;
  int         stall_cycles = 0;
  int         queued_total = 0;
  logic       in_fire = 1'b0;
  logic       out_fire = 1'b0;

  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int top);
    if (int'(v) < MIN_DIM) return MIN_DIM;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // Apply one request to the predicted grid and return the result it should give
  function automatic life_resp_t grid_response(input life_req_t rq);
    life_resp_t rs;
    bit         nxt [MAX_ROWS][MAX_COLS];
    int         nr, nc, cnt, pop, rr, cc;
    bit         in_area;
    rs = '0;
    nr = clamp_size(rows_cfg, MAX_ROWS);
    nc = clamp_size(cols_cfg, MAX_COLS);
    in_area = (int'(rq.row) < nr) && (int'(rq.col) < nc);
    case (rq.cmd)
      CMD_SET: begin
        if (in_area) grid_now[rq.row][rq.col] = 1'b1;
        else rs.status = STAT_OOB;
      end
      CMD_READ: begin
        if (in_area) rs.cell_value = grid_now[rq.row][rq.col];
        else rs.status = STAT_OOB;
      end
      CMD_STEP: begin
        // B3/S23 over the area in use; neighbors past the edge are dead
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            cnt = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
                  cnt += grid_now[rr][cc];
              end
            end
            nxt[r][c] = grid_now[r][c] ? (cnt == KEEP_N || cnt == BIRTH_N) : (cnt == BIRTH_N);
          end
        end
        pop = 0;
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            grid_now[r][c] = nxt[r][c];
            if (nxt[r][c] && pop < POP_SAT) pop++;
          end
        end
        rs.population = POP_W'(pop);
        rs.extinct = (pop == 0);
      end
      default: begin
        // clear wipes the whole store, in use or not
        for (int r = 0; r < MAX_ROWS; r++)
          for (int c = 0; c < MAX_COLS; c++)
            grid_now[r][c] = 1'b0;
      end
    endcase
    return rs;
  endfunction

  // Gap length per request, with occasional runs of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      calm = $urandom_range(6, 16);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Request driver: changes inputs on the falling edge
  int send_wait = 0;
  int send_calm = 0;
  always @(negedge clk) begin : driver
    logic      keep;
    life_req_t nx;
    keep = in_valid && !in_fire;
    if (!rst_n) begin
      keep = 1'b0;
    end else if (!keep) begin
      if (in_fire) send_wait = draw_wait(send_calm);
      if (send_wait > 0) begin
        send_wait--;
      end else if (cmd_backlog.size() > 0) begin
        nx = cmd_backlog.pop_front();
        in_cmd <= nx.cmd;
        in_row <= nx.row;
        in_col <= nx.col;
        keep = 1'b1;
      end
    end
    in_valid <= keep;
  end

  // Result receiver: stalls count only while a result is offered
  int take_wait = 0;
  int take_calm = 0;
  always @(negedge clk) begin : receiver
    if (out_fire) take_wait = draw_wait(take_calm);
    if (take_wait > 0 && out_valid) take_wait--;
    out_ready <= rst_n && (take_wait == 0);
  end

  // Monitor: check results against the oldest prediction, then predict new requests
  always @(posedge clk) begin : monitor
    life_resp_t got;
    due_entry_t head;
    due_entry_t fresh;
    in_fire  <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      got = {out_status, out_cell_value, out_extinct, out_population};
      if (due_responses.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("%0t: result with none outstanding: status=%0d cell=%0d extinct=%0d pop=%0d",
                   $realtime, got.status, got.cell_value, got.extinct, got.population);
      end else begin
        head = due_responses.pop_front();
        if (got.status !== head.rs.status || got.cell_value !== head.rs.cell_value ||
            got.extinct !== head.rs.extinct || got.population !== head.rs.population) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $write("%0t: cmd=%0d row=%0d col=%0d exp status=%0d cell=%0d extinct=%0d pop=%0d",
                   $realtime, head.rq.cmd, head.rq.row, head.rq.col,
                   head.rs.status, head.rs.cell_value, head.rs.extinct, head.rs.population);
            $display(", got status=%0d cell=%0d extinct=%0d pop=%0d",
                     got.status, got.cell_value, got.extinct, got.population);
          end
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      fresh.rq = {in_cmd, in_row, in_col};
      fresh.rs = grid_response(fresh.rq);
      due_responses.push_back(fresh);
    end
  end

  task automatic queue_req(input logic [1:0] cmd, input int r, input int c);
    life_req_t rq;
    rq.cmd = cmd;
    rq.row = ROW_W'(r);
    rq.col = COL_W'(c);
    cmd_backlog.push_back(rq);
    queued_total++;
  endtask

  // Hold off until every request is sent and answered
  task automatic wait_quiet();
    while (cmd_backlog.size() != 0 || in_valid || due_responses.size() != 0) @(posedge clk);
  endtask

  // APB write; only the low 7 bits of the data matter
  task automatic write_size(input logic reg_sel, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= ($urandom() & ~32'h7F) | (value & 32'h7F);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_ROWS) rows_cfg = CFG_W'(value);
    else cols_cfg = CFG_W'(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly small grids, some full size and some out of range on either side
  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 64;
      1: return $urandom_range(0, 1);
      2: return $urandom_range(65, 127);
      3: return $urandom_range(13, 40);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  // One random phase: seeded patterns that evolve, reads around them, some noise
  task automatic random_phase();
    int nr, nc, wr, wc, br, bc, n_steps;
    nr = clamp_size(rows_cfg, MAX_ROWS);
    nc = clamp_size(cols_cfg, MAX_COLS);
    wr = (nr < 5) ? nr : 5;
    wc = (nc < 5) ? nc : 5;
    repeat (2) begin
      br = $urandom_range(0, nr - wr);
      bc = $urandom_range(0, nc - wc);
      queue_req(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
      repeat ($urandom_range(2, (wr * wc < 10) ? wr * wc : 10))
        queue_req(CMD_SET, br + $urandom_range(0, wr - 1), bc + $urandom_range(0, wc - 1));
      n_steps = (nr * nc > 400) ? 1 : $urandom_range(1, 3);
      repeat (n_steps) begin
        queue_req(CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 3) == 0)
            queue_req(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63));
          else
            queue_req(CMD_READ, br + $urandom_range(0, wr - 1), bc + $urandom_range(0, wc - 1));
        end
      end
      // noise: any command, any index; steps only on modest grids
      repeat ($urandom_range(1, 3)) begin
        if (nr * nc > 400)
          queue_req($urandom_range(0, 1) ? CMD_SET : CMD_READ,
                    $urandom_range(0, 63), $urandom_range(0, 63));
        else
          queue_req(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63));
      end
    end
  endtask

  // Cycles with no accepted request or result
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int base;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Full 64 x 64 grid from reset: corners, isolated cells, blinker, corner block
    queue_req(CMD_READ, 0, 0);
    queue_req(CMD_SET, 0, 0);
    queue_req(CMD_SET, 63, 63);
    queue_req(CMD_SET, 0, 63);
    queue_req(CMD_SET, 63, 0);
    queue_req(CMD_READ, 63, 63);
    queue_req(CMD_STEP, 0, 0);
    queue_req(CMD_SET, 10, 20);
    queue_req(CMD_SET, 10, 21);
    queue_req(CMD_SET, 10, 22);
    queue_req(CMD_SET, 62, 62);
    queue_req(CMD_SET, 62, 63);
    queue_req(CMD_SET, 63, 62);
    queue_req(CMD_SET, 63, 63);
    queue_req(CMD_STEP, 63, 63);
    queue_req(CMD_READ, 9, 21);
    queue_req(CMD_CLEAR, 0, 0);
    queue_req(CMD_STEP, 0, 0);
    queue_req(CMD_SET, 40, 40);
    wait_quiet();

    // Sizes below range clamp to 2 x 2: bounds errors, then a birth
    write_size(REG_ROWS, 0);
    write_size(REG_COLS, 1);
    queue_req(CMD_SET, 2, 0);
    queue_req(CMD_READ, 0, 2);
    queue_req(CMD_SET, 1, 1);
    queue_req(CMD_SET, 0, 0);
    queue_req(CMD_SET, 0, 1);
    queue_req(CMD_STEP, 0, 0);
    queue_req(CMD_READ, 1, 0);
    wait_quiet();

    // Sizes above range clamp to 64: the cell outside the small area is still there
    write_size(REG_ROWS, 127);
    write_size(REG_COLS, 65);
    queue_req(CMD_READ, 40, 40);
    queue_req(CMD_STEP, 0, 0);
    wait_quiet();

    // Random phases, each with its own grid size
    base = queued_total;
    while (queued_total - base < RANDOM_REQS) begin
      write_size(REG_ROWS, pick_dim());
      write_size(REG_COLS, pick_dim());
      random_phase();
      wait_quiet();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_responses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
